FILE: rtl/fpld_pkg.sv
// Shared types and constants of the finder pattern line detector.
package fpld_pkg;

	localparam int PIX_W    = 8;
	localparam int POS_W    = 12;
	localparam int BND_W    = 13;
	localparam int NUM_BND  = 6;
	localparam int NUM_RUNS = 5;
	localparam int CNT_W    = 3;
	localparam int RUN_W    = 14;
	localparam int X_W      = 16;

	localparam logic [PIX_W-1:0] THRESH_RST = 8'd10;
	localparam logic [CNT_W-1:0] CNT_FULL   = 3'd6;

	typedef logic [BND_W-1:0] bnd_t;
	typedef bnd_t [NUM_BND-1:0] bnd_arr_t;
	typedef logic signed [X_W-1:0] xval_t;

	typedef struct packed {
		logic             emit;
		logic             decide;
		logic [POS_W-1:0] run_start;
		logic [POS_W-1:0] run_end;
	} trk_res_t;

endpackage

FILE: rtl/fpld_track.sv
// Per-line run tracker: dark/light boundaries, candidate start and decision point.
module fpld_track (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [7:0]                pixel_value,
	input  logic [11:0]               position,
	input  logic                      line_end,
	input  logic [7:0]                dark_threshold,
	output fpld_pkg::trk_res_t        res,
	output fpld_pkg::bnd_arr_t        bnd
);
	import fpld_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             dark_run_q, dark_run_n;
	logic [POS_W-1:0] start_q, start_n;
	logic             settled_q, settled_n;
	bnd_arr_t         bnd_q, bnd_n;
	logic             dark;
	logic             decide;
	bnd_t             pos_b;
	bnd_t             pos_next_b;

	assign dark       = pixel_value < dark_threshold;
	assign pos_b      = {1'b0, position};
	assign pos_next_b = pos_b + BND_W'(1);

	always_comb begin
		cnt_n      = cnt_q;
		dark_run_n = dark_run_q;
		start_n    = start_q;
		settled_n  = settled_q;
		bnd_n      = bnd_q;
		decide     = 1'b0;
		if (!settled_q) begin
			if (cnt_q == '0) begin
				if (dark) begin
					bnd_n[0]   = pos_b;
					cnt_n      = CNT_W'(1);
					dark_run_n = 1'b1;
					start_n    = position;
				end
			end else begin
				if ((dark_run_q != dark) && (cnt_q < CNT_FULL)) begin
					for (int i = 0; i < NUM_BND; i++) begin
						if (cnt_q == CNT_W'(i)) begin
							bnd_n[i] = pos_b;
						end
					end
					cnt_n      = cnt_q + CNT_W'(1);
					dark_run_n = !dark_run_q;
				end
				if (line_end && (cnt_n < CNT_FULL)) begin
					for (int i = 0; i < NUM_BND; i++) begin
						if (cnt_n == CNT_W'(i)) begin
							bnd_n[i] = pos_next_b;
						end
					end
					cnt_n = cnt_n + CNT_W'(1);
				end
				if (cnt_n == CNT_FULL) begin
					decide    = 1'b1;
					settled_n = 1'b1;
				end
			end
		end
	end

	assign res.emit      = !settled_q && (decide || line_end);
	assign res.decide    = decide;
	assign res.run_start = decide ? start_q : '0;
	assign res.run_end   = decide ? (position - POS_W'(1)) : '0;
	assign bnd           = bnd_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			dark_run_q <= 1'b0;
			start_q    <= '0;
			settled_q  <= 1'b0;
		end else if (en) begin
			if (line_end) begin
				cnt_q      <= '0;
				dark_run_q <= 1'b0;
				start_q    <= '0;
				settled_q  <= 1'b0;
			end else begin
				cnt_q      <= cnt_n;
				dark_run_q <= dark_run_n;
				start_q    <= start_n;
				settled_q  <= settled_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bnd_q <= bnd_n;
		end
	end

endmodule

FILE: rtl/fpld_ratio.sv
// Two-stage 1:1:3:1:1 run ratio test on six boundaries.
module fpld_ratio (
	input  logic               clk,
	input  logic               en,
	input  fpld_pkg::bnd_arr_t bnd,
	output logic               ok
);
	import fpld_pkg::*;

	xval_t x_n [NUM_RUNS];
	xval_t x_s3 [NUM_RUNS];

	always_comb begin
		logic signed [RUN_W-1:0] r;
		for (int i = 0; i < NUM_RUNS; i++) begin
			r = $signed({1'b0, bnd[i+1]}) - $signed({1'b0, bnd[i]});
			if (i == 2) begin
				x_n[i] = X_W'(r);
			end else begin
				x_n[i] = X_W'(r) + (X_W'(r) <<< 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= x_n;
		end
	end

	always_comb begin
		logic signed [X_W:0]   d;
		logic signed [X_W:0]   s;
		logic        [X_W:0]   ad;
		logic        [X_W+3:0] m5;
		ok = 1'b1;
		for (int i = 1; i < NUM_RUNS; i++) begin
			d  = (X_W+1)'(x_s3[i]) - (X_W+1)'(x_s3[i-1]);
			s  = (X_W+1)'(x_s3[i]) + (X_W+1)'(x_s3[i-1]);
			ad = d[X_W] ? (X_W+1)'(-d) : (X_W+1)'(d);
			m5 = ((X_W+4)'(ad) << 2) + (X_W+4)'(ad);
			if ($signed({1'b0, m5}) > (X_W+5)'(s)) begin
				ok = 1'b0;
			end
		end
	end

endmodule

FILE: rtl/finder_pattern_line_detector_unit.sv
// Top level of the finder pattern line detector with stream channels and threshold register.
//
// Pixels of one scan line enter on the s_axis channel, one per transfer, with
// tlast on the last pixel of the line. A pixel is dark when its gray value is
// below the threshold written on the cfg channel (reset value 10). The block
// returns at most one result per pixel on m_axis: a decision once six run
// boundaries are held, or a not-found result at the end of a line that never
// got that far. tuser carries the found flag.
// One pixel is taken every cycle while the output can move. A result passes
// the input register, the tracker stage and a two-stage ratio test feeding
// the output register before it appears on m_axis.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready stays low until that result is taken.
// Reset clears the line state, empties the pipeline and restores the threshold.
module finder_pattern_line_detector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // pixel_value[7:0], position[19:8], zero pad
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // run_start[11:0], run_end[23:12]
	output logic        m_axis_tuser,   // found[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import fpld_pkg::*;

	logic             adv;
	logic [7:0]       thresh_q;

	logic             valid_s1;
	logic [7:0]       pix_s1;
	logic [11:0]      pos_s1;
	logic             last_s1;

	trk_res_t         trk_res;
	bnd_arr_t         trk_bnd;

	logic             valid_s2;
	logic             decide_s2;
	logic [11:0]      start_s2;
	logic [11:0]      end_s2;
	bnd_arr_t         bnd_s2;

	logic             valid_s3;
	logic             decide_s3;
	logic [11:0]      start_s3;
	logic [11:0]      end_s3;
	logic             ratio_ok;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
		end else if (cfg_valid) begin
			thresh_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			valid_s1      <= s_axis_tvalid;
			valid_s2      <= valid_s1 && trk_res.emit;
			valid_s3      <= valid_s2;
			m_axis_tvalid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1       <= s_axis_tdata[7:0];
			pos_s1       <= s_axis_tdata[19:8];
			last_s1      <= s_axis_tlast;
			decide_s2    <= trk_res.decide;
			start_s2     <= trk_res.run_start;
			end_s2       <= trk_res.run_end;
			bnd_s2       <= trk_bnd;
			decide_s3    <= decide_s2;
			start_s3     <= start_s2;
			end_s3       <= end_s2;
			m_axis_tuser <= decide_s3 && ratio_ok;
			m_axis_tdata <= {end_s3, start_s3};
		end
	end

	fpld_track u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (valid_s1 && adv),
		.pixel_value    (pix_s1),
		.position       (pos_s1),
		.line_end       (last_s1),
		.dark_threshold (thresh_q),
		.res            (trk_res),
		.bnd            (trk_bnd)
	);

	fpld_ratio u_ratio (
		.clk (clk),
		.en  (adv),
		.bnd (bnd_s2),
		.ok  (ratio_ok)
	);

endmodule
